@@ hdl/dbcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcc_pkg
// Shared widths, constants, command codes and status types for the
// delay-based gain update block.
// ----------------------------------------------------------------------------
package dbcc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int DLY_W      = 22;
	localparam int SUM_W      = DLY_W + COUNT_BITS;
	// widest dividend: delay sum, or a 22-bit delay times an 11-bit gain
	localparam int DIV_W      = (SUM_W > 33) ? SUM_W : 33;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

	localparam int ALPHA_W    = 11;
	localparam int BETA_W     = 6;
	localparam int GEN_W      = 4;
	localparam int RTT_W      = 32;
	localparam int IN_TDATA_W = 3 * RTT_W;
	localparam int OUT_TDATA_W = 8 * ((ALPHA_W + BETA_W + 7) / 8);

	localparam logic [ALPHA_W-1:0] ALPHA_TOP = 11'd1280;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 11'd128;
	localparam logic [ALPHA_W-1:0] ALPHA_HALF_SPAN = 11'd621; // (ALPHA_TOP - 38) / 2
	localparam logic [ALPHA_W-1:0] ALPHA_LOW = 11'd38;
	localparam logic [BETA_W-1:0]  BETA_TOP  = 6'd32;
	localparam logic [BETA_W-1:0]  BETA_LOW  = 6'd8;
	localparam logic [DLY_W-1:0]   DELAY_CAP = 22'd3355443;
	localparam logic [RTT_W-1:0]   MIN_RESET = 32'h7fff_ffff;
	localparam logic [GEN_W-1:0]   GEN_RESET = 4'd5;

	// reciprocal constants: floor(n / d) = (n * ceil(2^k / d)) >> k over the used range
	localparam int          RECIP_SH   = 29;
	localparam int          RECIP19_SH = 36;
	localparam logic [22:0] RECIP_100  = 23'd5368710;     // ceil(2^29 / 100), n < 2^22
	localparam logic [25:0] RECIP_10   = 26'd53687092;    // ceil(2^29 / 10), n < 2^25
	localparam logic [31:0] RECIP_19   = 32'd3616814566;  // ceil(2^36 / 19), n < 2^31

	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_EPOCH  = 2'd1;
	localparam logic [1:0] REQ_LOSS   = 2'd2;

	typedef logic [4:0] op_t;

	localparam op_t OP_NONE      = 5'd0;
	localparam op_t OP_CAPTURE   = 5'd1;
	localparam op_t OP_SAMPLE    = 5'd2;
	localparam op_t OP_LOSS      = 5'd3;
	localparam op_t OP_SLOW      = 5'd4;
	localparam op_t OP_CLEAR     = 5'd5;
	localparam op_t OP_DIV_AVG   = 5'd6;
	localparam op_t OP_RECIP_T   = 5'd8;
	localparam op_t OP_DIV_QA    = 5'd9;
	localparam op_t OP_DIV_QB    = 5'd12;
	localparam op_t OP_SET_DA    = 5'd13;
	localparam op_t OP_SET_D1    = 5'd14;
	localparam op_t OP_ALOW      = 5'd15;
	localparam op_t OP_SUBA      = 5'd16;
	localparam op_t OP_MUL1      = 5'd17;
	localparam op_t OP_SET_T     = 5'd18;
	localparam op_t OP_MUL2      = 5'd19;
	localparam op_t OP_SET_QA    = 5'd20;
	localparam op_t OP_SET_D2    = 5'd21;
	localparam op_t OP_SET_D3    = 5'd22;
	localparam op_t OP_SET_QB    = 5'd23;
	localparam op_t OP_BETA_LOW  = 5'd24;
	localparam op_t OP_BETA_TOP  = 5'd25;
	localparam op_t OP_LOAD_OUT  = 5'd26;

	typedef struct packed {
		logic [1:0] req;
		logic       win_lt;
		logic       cnt_zero;
		logic       da_le_d1;
		logic       da_le_d2;
		logic       beta_top;
		logic       div_done;
	} status_t;

endpackage

@@ hdl/dbcc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcc_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module dbcc_div import dbcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic [DIV_W-1:0] quo,
	output logic             done
);

	logic [DIV_W:0]         rem_q;
	logic [DIV_W-1:0]       quo_q;
	logic [DIV_W-1:0]       den_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DIV_W:0]         rem_sh;
	logic [DIV_W:0]         diff;

	always_comb begin
		rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
		diff   = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

@@ hdl/dbcc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcc_dp
// Datapath: delay statistics, gain registers, work registers and divider.
// ----------------------------------------------------------------------------
module dbcc_dp import dbcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  op_t                   op,
	output status_t               st,
	input  logic [IN_TDATA_W-1:0] in_tdata,
	input  logic [1:0]            in_tuser,
	input  logic                  cfg_valid,
	input  logic [GEN_W-1:0]      cfg_data,
	output logic [ALPHA_W-1:0]    out_alpha,
	output logic [BETA_W-1:0]     out_beta
);

	logic [GEN_W-1:0]      gen_q;
	logic [RTT_W-1:0]      mn_q;
	logic [DLY_W-1:0]      mx_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [SUM_W-1:0]      sum_q;
	logic [GEN_W-1:0]      lec_q;
	logic                  wa_q;
	logic [ALPHA_W-1:0]    alpha_q;
	logic [BETA_W-1:0]     beta_q;
	logic [ALPHA_W-1:0]    oalpha_q;
	logic [BETA_W-1:0]     obeta_q;

	logic [1:0]            req_q;
	logic [RTT_W-1:0]      rtt_q;
	logic                  lt_q;
	logic [DLY_W-1:0]      dm_q, da_q, d1_q, d2_q, d3_q, dmp_q, dap_q;
	logic [DIV_W-1:0]      tmp_q, den_q;

	logic                  div_start;
	logic [DIV_W-1:0]      div_num, div_den, quo;
	logic                  div_done;
	logic [DLY_W-1:0]      s_clamp, dm_n, da_n;
	logic [GEN_W-1:0]      lec_n;
	logic [50:0]           p_d1, p_d2, p_d3;
	logic [62:0]           p_t;

	dbcc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (quo),
		.done  (div_done)
	);

	always_comb begin
		div_start = 1'b1;
		div_num   = '0;
		div_den   = DIV_W'(1);
		unique case (op)
			OP_DIV_AVG: begin
				div_num = DIV_W'(sum_q);
				div_den = DIV_W'(cnt_q);
			end
			OP_DIV_QA: begin
				div_num = tmp_q;
				div_den = den_q;
			end
			OP_DIV_QB: begin
				div_num = (DIV_W'(d3_q) << 3) + DIV_W'(da_q) * DIV_W'(24)
					- (DIV_W'(d2_q) << 5);
				div_den = DIV_W'(d3_q - d2_q);
			end
			default: div_start = 1'b0;
		endcase
	end

	always_comb begin
		s_clamp = (rtt_q > RTT_W'(DELAY_CAP)) ? DELAY_CAP : rtt_q[DLY_W-1:0];
		dm_n    = ({{(RTT_W-DLY_W){1'b0}}, mx_q} > mn_q) ? (mx_q - mn_q[DLY_W-1:0]) : '0;
		da_n    = (quo > DIV_W'(mn_q)) ? DLY_W'(quo - DIV_W'(mn_q)) : '0;
		lec_n   = lec_q + 1'b1;
		// constant divisions by reciprocal multiply
		p_d1    = 51'(dm_q) * 51'(RECIP_100);
		p_d2    = 51'(dm_q) * 51'(RECIP_10);
		p_d3    = 51'({dm_q, 3'b000}) * 51'(RECIP_10);
		p_t     = 63'(tmp_q[30:0]) * 63'(RECIP_19);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q    <= GEN_RESET;
			mn_q     <= MIN_RESET;
			mx_q     <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			lec_q    <= '0;
			wa_q     <= 1'b0;
			alpha_q  <= ALPHA_TOP;
			beta_q   <= BETA_TOP;
			oalpha_q <= ALPHA_TOP;
			obeta_q  <= BETA_TOP;
		end else begin
			if (cfg_valid)
				gen_q <= cfg_data;
			unique case (op)
				OP_SAMPLE: begin
					if ({{(RTT_W-DLY_W){1'b0}}, s_clamp} < mn_q)
						mn_q <= RTT_W'(s_clamp);
					if (s_clamp > mx_q)
						mx_q <= s_clamp;
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + 1'b1;
						sum_q <= sum_q + SUM_W'(s_clamp);
					end
				end
				OP_LOSS: begin
					alpha_q <= ALPHA_ONE;
					beta_q  <= BETA_TOP;
					lec_q   <= '0;
					wa_q    <= 1'b0;
					cnt_q   <= '0;
					sum_q   <= '0;
				end
				OP_SLOW: begin
					alpha_q <= ALPHA_ONE;
					beta_q  <= BETA_TOP;
					cnt_q   <= '0;
					sum_q   <= '0;
				end
				OP_CLEAR: begin
					cnt_q <= '0;
					sum_q <= '0;
				end
				OP_ALOW: begin
					if (!wa_q) begin
						alpha_q <= ALPHA_TOP;
					end else if (lec_n < gen_q) begin
						lec_q <= lec_n;
					end else begin
						lec_q   <= '0;
						wa_q    <= 1'b0;
						alpha_q <= ALPHA_TOP;
					end
				end
				OP_SUBA: wa_q <= 1'b1;
				OP_SET_QA:
					alpha_q <= (quo > DIV_W'(ALPHA_TOP)) ? ALPHA_TOP : quo[ALPHA_W-1:0];
				OP_SET_QB:
					beta_q <= (quo > DIV_W'(BETA_TOP)) ? BETA_TOP : quo[BETA_W-1:0];
				OP_BETA_LOW: beta_q <= BETA_LOW;
				OP_BETA_TOP: beta_q <= BETA_TOP;
				OP_LOAD_OUT: begin
					oalpha_q <= alpha_q;
					obeta_q  <= beta_q;
				end
				default: ;
			endcase
		end
	end

	// work registers, no reset
	always_ff @(posedge clk) begin
		unique case (op)
			OP_CAPTURE: begin
				req_q <= in_tuser;
				rtt_q <= in_tdata[RTT_W-1:0];
				lt_q  <= in_tdata[2*RTT_W-1:RTT_W] < in_tdata[3*RTT_W-1:2*RTT_W];
			end
			OP_SET_DA: begin
				dm_q <= dm_n;
				da_q <= da_n;
			end
			OP_SET_D1: d1_q <= p_d1[RECIP_SH +: DLY_W];
			OP_SUBA: begin
				dmp_q <= dm_q - d1_q;
				dap_q <= da_q - d1_q;
			end
			// da * 1242 / 38 taken as da * 621 / 19
			OP_MUL1: tmp_q <= DIV_W'(dap_q) * DIV_W'(ALPHA_HALF_SPAN);
			OP_RECIP_T: den_q <= DIV_W'(p_t[62:RECIP19_SH]);
			OP_SET_T: den_q <= den_q + DIV_W'(dmp_q);
			OP_MUL2: tmp_q <= DIV_W'(dmp_q) * DIV_W'(ALPHA_TOP);
			OP_SET_D2: d2_q <= p_d2[RECIP_SH +: DLY_W];
			OP_SET_D3: d3_q <= p_d3[RECIP_SH +: DLY_W];
			default: ;
		endcase
	end

	always_comb begin
		st.req      = req_q;
		st.win_lt   = lt_q;
		st.cnt_zero = (cnt_q == '0);
		st.da_le_d1 = (da_q <= d1_q);
		st.da_le_d2 = (da_q <= d2_q);
		st.beta_top = (da_q >= d3_q) || (d3_q <= d2_q);
		st.div_done = div_done;
	end

	assign out_alpha = oalpha_q;
	assign out_beta  = obeta_q;

endmodule

@@ hdl/dbcc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcc_ctrl
// Sequencer: steps the datapath through each request and owns the handshakes.
// ----------------------------------------------------------------------------
module dbcc_ctrl import dbcc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t st,
	output op_t     op
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_DIVW = 5'd2;
	localparam logic [4:0] S_SDA  = 5'd3;
	localparam logic [4:0] S_SD1  = 5'd5;
	localparam logic [4:0] S_ABR  = 5'd6;
	localparam logic [4:0] S_ALOW = 5'd7;
	localparam logic [4:0] S_SUBA = 5'd8;
	localparam logic [4:0] S_MUL1 = 5'd9;
	localparam logic [4:0] S_DT   = 5'd10;
	localparam logic [4:0] S_ST   = 5'd11;
	localparam logic [4:0] S_MUL2 = 5'd12;
	localparam logic [4:0] S_DQA  = 5'd13;
	localparam logic [4:0] S_SQA  = 5'd14;
	localparam logic [4:0] S_D2   = 5'd15;
	localparam logic [4:0] S_BBR  = 5'd17;
	localparam logic [4:0] S_D3   = 5'd18;
	localparam logic [4:0] S_BBR2 = 5'd20;
	localparam logic [4:0] S_SQB  = 5'd21;
	localparam logic [4:0] S_CLR  = 5'd22;
	localparam logic [4:0] S_FIN  = 5'd23;

	logic [4:0] state_q, state_n, ret_q, ret_n;
	logic       ovalid_q;
	logic       out_free;

	assign out_free = !ovalid_q || m_tready;

	always_comb begin
		state_n = state_q;
		ret_n   = ret_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE: if (s_tvalid) begin
				op      = OP_CAPTURE;
				state_n = S_DISP;
			end
			S_DISP: begin
				state_n = S_FIN;
				priority if (st.req == REQ_SAMPLE) begin
					op = OP_SAMPLE;
				end else if (st.req == REQ_LOSS) begin
					op = OP_LOSS;
				end else if (st.req == REQ_EPOCH) begin
					priority if (st.win_lt) begin
						op = OP_SLOW;
					end else if (st.cnt_zero) begin
						op = OP_CLEAR;
					end else begin
						op      = OP_DIV_AVG;
						ret_n   = S_SDA;
						state_n = S_DIVW;
					end
				end else begin
					op = OP_NONE;
				end
			end
			S_DIVW: if (st.div_done) state_n = ret_q;
			S_SDA: begin
				op      = OP_SET_DA;
				state_n = S_SD1;
			end
			S_SD1: begin
				op      = OP_SET_D1;
				state_n = S_ABR;
			end
			S_ABR: state_n = st.da_le_d1 ? S_ALOW : S_SUBA;
			S_ALOW: begin
				op      = OP_ALOW;
				state_n = S_D2;
			end
			S_SUBA: begin
				op      = OP_SUBA;
				state_n = S_MUL1;
			end
			S_MUL1: begin
				op      = OP_MUL1;
				state_n = S_DT;
			end
			S_DT: begin
				op      = OP_RECIP_T;
				state_n = S_ST;
			end
			S_ST: begin
				op      = OP_SET_T;
				state_n = S_MUL2;
			end
			S_MUL2: begin
				op      = OP_MUL2;
				state_n = S_DQA;
			end
			S_DQA: begin
				op      = OP_DIV_QA;
				ret_n   = S_SQA;
				state_n = S_DIVW;
			end
			S_SQA: begin
				op      = OP_SET_QA;
				state_n = S_D2;
			end
			S_D2: begin
				op      = OP_SET_D2;
				state_n = S_BBR;
			end
			S_BBR: if (st.da_le_d2) begin
				op      = OP_BETA_LOW;
				state_n = S_CLR;
			end else begin
				state_n = S_D3;
			end
			S_D3: begin
				op      = OP_SET_D3;
				state_n = S_BBR2;
			end
			S_BBR2: if (st.beta_top) begin
				op      = OP_BETA_TOP;
				state_n = S_CLR;
			end else begin
				op      = OP_DIV_QB;
				ret_n   = S_SQB;
				state_n = S_DIVW;
			end
			S_SQB: begin
				op      = OP_SET_QB;
				state_n = S_CLR;
			end
			S_CLR: begin
				op      = OP_CLEAR;
				state_n = S_FIN;
			end
			S_FIN: if (out_free) begin
				op      = OP_LOAD_OUT;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			ret_q   <= ret_n;
			// hold the result until taken; a new one may replace it in the same cycle
			if (op == OP_LOAD_OUT)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovalid_q;

endmodule

@@ hdl/delay_based_cc_gain_update_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_based_cc_gain_update_top
// Delay-based additive/multiplicative gain update with one result per request.
// ----------------------------------------------------------------------------
// Requests are taken one at a time; each gives one result transaction with the
// current alpha (Q7) and beta (Q6). RTT samples, loss resets, slow-start and
// empty epoch updates, and unused kinds pass from capture through the dispatch
// state to the final state, which loads the result; the next request is taken
// once back in idle. An epoch update with samples runs a shared restoring
// divider (one quotient bit per cycle, DIV_W = 38 bits) for the average and,
// in the worst case, the alpha and beta quotients; the divisions by 10, 100
// and 38 are reciprocal multiplies. The worst case is set by the three divider
// passes. The result waits in an output register while the next request is
// accepted; a request only finishes once the previous result has been taken.
module delay_based_cc_gain_update_top import dbcc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // rtt_sample, window_now, slow_start_limit
	input  logic [1:0]             s_axis_tuser,  // req_type
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // gain_increase, gain_decrease, zero pad
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [GEN_W-1:0]       cfg_data       // good_epochs_needed
);

	op_t                op;
	status_t            st;
	logic [ALPHA_W-1:0] alpha;
	logic [BETA_W-1:0]  beta;

	dbcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.st      (st),
		.op      (op)
	);

	dbcc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.st       (st),
		.in_tdata (s_axis_tdata),
		.in_tuser (s_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.out_alpha(alpha),
		.out_beta (beta)
	);

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {{(OUT_TDATA_W-ALPHA_W-BETA_W){1'b0}}, beta, alpha};

endmodule

@@ hdl/dbcc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcc_checker
// Port-level checks for the gain update block, bound to the top level.
// ----------------------------------------------------------------------------
module dbcc_checker import dbcc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[ALPHA_W-1:0] <= ALPHA_TOP
			&& m_axis_tdata[ALPHA_W+BETA_W-1:ALPHA_W] <= BETA_TOP
			&& m_axis_tdata[ALPHA_W+BETA_W-1:ALPHA_W] >= BETA_LOW)
		else $error("gain out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");

endmodule

bind delay_based_cc_gain_update_top dbcc_checker u_dbcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

@@ bench/tb_delay_based_cc_gain_update_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delay_based_cc_gain_update_top
// Self-checking bench for the delay-based alpha/beta gain update block.
// ----------------------------------------------------------------------------
// Drives RTT samples, epoch updates, loss resets and the unused request kind,
// predicts every result with a local model of the gain state, and compares
// each output transaction in order. Both stream sides idle at random, but for one random run.
module tb_delay_based_cc_gain_update_top;
	import dbcc_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int         CNT_MAX    = (1 << COUNT_BITS) - 1;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [BETA_W-1:0]  beta;
	} gains_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [GEN_W-1:0]       cfg_data = '0;

	// gain model state
	logic [GEN_W-1:0] good_needed;
	logic [31:0]      min_dly;
	logic [31:0]      max_dly;
	logic [31:0]      n_samples;
	logic [63:0]      dly_sum;
	logic [3:0]       low_epochs;
	logic             above;
	logic [ALPHA_W-1:0] alpha_cur;
	logic [BETA_W-1:0]  beta_cur;

	gains_t pending_gains[$];
	int     err_count = 0;
	bit     idle_on = 1'b1;

	delay_based_cc_gain_update_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= idle_on ? ($urandom_range(99) >= 38) : 1'b1;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic logic [ALPHA_W-1:0] calc_alpha(input logic [63:0] da,
			input logic [63:0] dm);
		logic [63:0] d1;
		logic [63:0] q;
		d1 = dm / 100;
		if (da <= d1) begin
			if (!above)
				return ALPHA_TOP;
			low_epochs = low_epochs + 4'd1;
			if (low_epochs < good_needed)
				return alpha_cur;
			low_epochs = '0;
			above = 1'b0;
			return ALPHA_TOP;
		end
		above = 1'b1;
		dm = dm - d1;
		da = da - d1;
		q = (dm * 1280) / (dm + (da * 1242) / 38);
		return (q > 1280) ? ALPHA_TOP : q[ALPHA_W-1:0];
	endfunction

	function automatic logic [BETA_W-1:0] calc_beta(input logic [63:0] da,
			input logic [63:0] dm);
		logic [63:0] d2;
		logic [63:0] d3;
		logic [63:0] q;
		d2 = dm / 10;
		if (da <= d2)
			return BETA_LOW;
		d3 = (8 * dm) / 10;
		if (da >= d3 || d3 <= d2)
			return BETA_TOP;
		q = (8 * d3 + 24 * da - 32 * d2) / (d3 - d2);
		return (q > 32) ? BETA_TOP : q[BETA_W-1:0];
	endfunction

	task automatic predict_gains(input logic [1:0] kind, input logic [31:0] rtt,
			input logic [31:0] win, input logic [31:0] lim);
		logic [31:0] s;
		logic [63:0] avg;
		logic [63:0] dm;
		logic [63:0] da;
		gains_t g;
		case (kind)
			REQ_SAMPLE: begin
				s = (rtt > 32'(DELAY_CAP)) ? 32'(DELAY_CAP) : rtt;
				if (s < min_dly) min_dly = s;
				if (s > max_dly) max_dly = s;
				if (n_samples < CNT_MAX) begin
					n_samples++;
					dly_sum += s;
				end
			end
			REQ_EPOCH: begin
				if (win < lim) begin
					alpha_cur = ALPHA_ONE;
					beta_cur = BETA_TOP;
				end else if (n_samples > 0) begin
					avg = dly_sum / n_samples;
					dm = (max_dly > min_dly) ? 64'(max_dly - min_dly) : 64'd0;
					da = (avg > min_dly) ? avg - min_dly : 64'd0;
					alpha_cur = calc_alpha(da, dm);
					beta_cur = calc_beta(da, dm);
				end
				n_samples = 0;
				dly_sum = 0;
			end
			REQ_LOSS: begin
				alpha_cur = ALPHA_ONE;
				beta_cur = BETA_TOP;
				low_epochs = '0;
				above = 1'b0;
				n_samples = 0;
				dly_sum = 0;
			end
			default: ;
		endcase
		g.alpha = alpha_cur;
		g.beta = beta_cur;
		pending_gains.push_back(g);
	endtask

	// one request transaction; leaves the clock at the accepting edge
	task automatic send_req(input logic [1:0] kind, input logic [31:0] rtt,
			input logic [31:0] win, input logic [31:0] lim);
		@(negedge clk);
		if (idle_on && $urandom_range(99) < 38) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {lim, win, rtt};
		do @(posedge clk); while (!s_axis_tready);
		predict_gains(kind, rtt, win, lim);
	endtask

	task automatic sample(input logic [31:0] rtt);
		send_req(REQ_SAMPLE, rtt, $urandom, $urandom);
	endtask

	task automatic epoch();
		logic [31:0] w;
		w = $urandom;
		send_req(REQ_EPOCH, $urandom, w, $urandom_range(w));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_gains.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_good_needed(input logic [GEN_W-1:0] val);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		good_needed = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		gains_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_gains.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = pending_gains.pop_front();
				if (m_axis_tdata[ALPHA_W-1:0] !== want.alpha)
					report_mismatch($sformatf("gain_increase %0d, want %0d",
						m_axis_tdata[ALPHA_W-1:0], want.alpha));
				if (m_axis_tdata[ALPHA_W+BETA_W-1:ALPHA_W] !== want.beta)
					report_mismatch($sformatf("gain_decrease %0d, want %0d",
						m_axis_tdata[ALPHA_W+BETA_W-1:ALPHA_W], want.beta));
				if (m_axis_tdata[OUT_TDATA_W-1:ALPHA_W+BETA_W] !== '0)
					report_mismatch("pad bits not zero");
			end
		end
	end

	task automatic test_directed();
		sample(32'd0);
		sample(32'hFFFF_FFFF);
		sample(32'(DELAY_CAP));
		sample(32'(DELAY_CAP) + 32'd1);
		send_req(REQ_EPOCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_req(REQ_EPOCH, 32'h0, 32'h0, 32'h0);           // no samples: hold gains
		send_req(REQ_EPOCH, 32'h0, 32'd0, 32'hFFFF_FFFF);   // slow start
		send_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		sample(32'd500);
		sample(32'd500);
		send_req(REQ_EPOCH, 32'h0, 32'd7, 32'd7);           // equal window and limit
		send_req(REQ_LOSS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		sample(32'd2_000_000);
		sample(32'd1_000);
		epoch();
		send_req(REQ_UNUSED, 32'h0, 32'h0, 32'h0);
		send_req(REQ_LOSS, 32'h0, 32'h0, 32'h0);
	endtask

	// high epoch, then runs of low epochs to exercise the recovery count
	task automatic test_recovery(input logic [GEN_W-1:0] need);
		logic [31:0] base;
		write_good_needed(need);
		base = min_dly;
		sample(base + 32'd200_000);
		epoch();
		for (int r = 0; r < 2; r++) begin
			sample(base + 32'd100_000);
			epoch();
			for (int e = 0; e < 17; e++) begin
				sample(base);
				epoch();
			end
		end
	endtask

	task automatic test_random(input int n_items);
		int done;
		int burst;
		logic [31:0] base;
		logic [31:0] spread;
		done = 0;
		while (done < n_items) begin
			case ($urandom_range(9))
				0: begin
					send_req(REQ_LOSS, $urandom, $urandom, $urandom);
					done++;
				end
				1: begin
					send_req(REQ_UNUSED, $urandom, $urandom, $urandom);
					done++;
				end
				2: begin
					send_req(REQ_EPOCH, $urandom, $urandom_range(1000),
						32'd1001 + $urandom_range(1000));
					done++;
				end
				3: begin
					sample($urandom);
					done++;
				end
				default: begin
					burst = $urandom_range(1, 8);
					base = $urandom_range(3_400_000);
					spread = 32'd1 << $urandom_range(21);
					for (int k = 0; k < burst; k++)
						sample(($urandom_range(3) == 0) ? min_dly
							: base + $urandom_range(spread));
					epoch();
					done += burst + 1;
				end
			endcase
		end
	endtask

	initial begin
		good_needed = GEN_RESET;
		min_dly = MIN_RESET;
		max_dly = '0;
		n_samples = 0;
		dly_sum = 0;
		low_epochs = '0;
		above = 1'b0;
		alpha_cur = ALPHA_TOP;
		beta_cur = BETA_TOP;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_recovery(4'd5);
		test_recovery(4'd1);
		test_recovery(4'd15);
		test_recovery(4'd0);
		write_good_needed(4'($urandom_range(1, 15)));
		test_random(50);
		idle_on = 1'b0;
		test_random(60);
		idle_on = 1'b1;
		wait_drain();
		test_random(40);
		write_good_needed(4'($urandom_range(15)));
		test_random(40);

		wait_drain();
		repeat (400) @(negedge clk);
		if (err_count == 0 && pending_gains.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#100_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/dbcc_pkg.sv
hdl/dbcc_div.sv
hdl/dbcc_dp.sv
hdl/dbcc_ctrl.sv
hdl/delay_based_cc_gain_update_top.sv
hdl/dbcc_checker.sv
bench/tb_delay_based_cc_gain_update_top.sv
